FILE: rtl/swb_pkg.sv
// shared constants, types and helper functions of the subtract-with-borrow generator
`default_nettype none
package swb_pkg;

  localparam int LONG_LAG   = 128;
  localparam int SHORT_LAG  = 54;
  localparam int WORD_WIDTH = 64;
  localparam int PTR_W      = (LONG_LAG > 1) ? $clog2(LONG_LAG) : 1;
  localparam int LAG_MOD    = SHORT_LAG % LONG_LAG;
  localparam int BACK_OFS   = LONG_LAG - LAG_MOD;
  localparam int TDATA_W    = ((WORD_WIDTH + 7) / 8) * 8;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [TDATA_W-1:0]    tdata_t;

  typedef enum logic {
    OP_SEED = 1'b0,
    OP_GEN  = 1'b1
  } op_t;

  typedef struct packed {
    logic en;
    ptr_t cur;
    ptr_t back;
  } ring_rd_t;

  typedef struct packed {
    logic  en;
    ptr_t  addr;
    word_t data;
  } ring_wr_t;

  typedef struct packed {
    logic  valid;
    logic  ready;
    ptr_t  ptr;
    word_t result;
  } core_stat_t;

  function automatic ptr_t next_slot(ptr_t p);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W+1)'(1);
    if (s >= (PTR_W+1)'(LONG_LAG)) begin
      s = '0;
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic ptr_t lag_slot(ptr_t p);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W+1)'(BACK_OFS);
    if (s >= (PTR_W+1)'(LONG_LAG)) begin
      s = s - (PTR_W+1)'(LONG_LAG);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/swb_ring.sv
// lag ring memory: two registered read ports, one write port, write forwarding
`default_nettype none
module swb_ring (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire swb_pkg::ring_rd_t rd,
  input  wire swb_pkg::ring_wr_t wr,
  output swb_pkg::word_t         old_word,
  output swb_pkg::word_t         lag_word
);
  import swb_pkg::*;

  word_t               mem [LONG_LAG];
  logic [LONG_LAG-1:0] vld;
  word_t               old_q;
  word_t               lag_q;
  logic                old_vld;
  logic                lag_vld;
  logic                hit_cur;
  logic                hit_back;

  assign hit_cur  = wr.en && (wr.addr == rd.cur);
  assign hit_back = wr.en && (wr.addr == rd.back);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      old_q <= hit_cur  ? wr.data : mem[rd.cur];
      lag_q <= hit_back ? wr.data : mem[rd.back];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      old_vld <= 1'b0;
      lag_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        old_vld <= hit_cur  || vld[rd.cur];
        lag_vld <= hit_back || vld[rd.back];
      end
    end
  end

  assign old_word = old_vld ? old_q : '0;
  assign lag_word = lag_vld ? lag_q : '0;

endmodule
`default_nettype wire

FILE: rtl/swb_core.sv
// slot pointer, request stage, borrow word and the word update
`default_nettype none
module swb_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire swb_pkg::op_t        in_op,
  input  wire swb_pkg::word_t      in_seed,
  input  wire logic                out_free,
  input  wire swb_pkg::word_t      old_word,
  input  wire swb_pkg::word_t      lag_word,
  output swb_pkg::ring_rd_t        rd,
  output swb_pkg::ring_wr_t        wr,
  output swb_pkg::core_stat_t      stat
);
  import swb_pkg::*;

  ptr_t  ptr;
  ptr_t  addr;
  logic  busy;
  op_t   op;
  word_t seed;
  word_t borrow;
  word_t borrow_next;
  word_t result;
  logic  adv;
  logic  ready;
  logic  accept;

  assign adv    = busy && out_free;
  assign ready  = !busy || adv;
  assign accept = in_valid && ready;

  always_comb begin
    borrow_next = borrow;
    unique case (op)
      OP_SEED: begin
        result = seed;
      end
      OP_GEN: begin
        result      = old_word ^ lag_word ^ borrow;
        borrow_next = (~old_word & borrow) | (~old_word & lag_word) | (lag_word & borrow);
      end
      default: begin
        result = seed;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      busy   <= 1'b0;
      borrow <= '0;
    end else begin
      if (accept) begin
        ptr <= next_slot(ptr);
      end
      if (adv) begin
        borrow <= borrow_next;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (adv) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr <= ptr;
      op   <= in_op;
      seed <= in_seed;
    end
  end

  assign rd.en   = accept;
  assign rd.cur  = ptr;
  assign rd.back = lag_slot(ptr);

  assign wr.en   = adv;
  assign wr.addr = addr;
  assign wr.data = result;

  assign stat.valid  = busy;
  assign stat.ready  = ready;
  assign stat.ptr    = ptr;
  assign stat.result = result;

endmodule
`default_nettype wire

FILE: rtl/bitsliced_subtract_with_borrow_rng.sv
// top level of the bit-sliced subtract-with-borrow word generator
//
// Usage:
//   Slave channel s_*: one request per accepted beat. s_tuser[0] selects the
//   operation (0 loads s_tdata as seed into the current slot, 1 generates the
//   next word); s_tdata carries the seed word, ignored when generating.
//   Master channel m_*: exactly one word per request, in request order; a
//   seed request echoes its seed, a generate request returns the new word.
//   Path: an accepted request is registered in the request stage, then in
//   the output register driving m_tdata once the output is free.
//   Throughput: one request per cycle while the output is free, set by
//   the single ring update per cycle (two registered reads and one write of
//   the lag ring, the write forwarded into a same-slot read in that cycle).
//   Reset (rst, synchronous): slot pointer and borrow word go to zero and
//   the ring reads as all zeros through per-slot valid bits, so no clearing
//   pass is needed and requests are taken in the first cycle after reset.
//   Stall: while m_tready is low the output register and the request stage
//   hold their words; s_tready drops once both are occupied.
`default_nettype none
module bitsliced_subtract_with_borrow_rng (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire swb_pkg::tdata_t s_tdata,  // seed_word
  input  wire logic [0:0]      s_tuser,  // operation
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output swb_pkg::tdata_t      m_tdata   // word
);
  import swb_pkg::*;

  ring_rd_t   rd;
  ring_wr_t   wr;
  core_stat_t stat;
  word_t      old_word;
  word_t      lag_word;
  word_t      out_word;
  logic       out_free;
  logic       load;

  assign out_free = !m_tvalid || m_tready;
  assign load     = stat.valid && out_free;

  swb_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .wr       (wr),
    .old_word (old_word),
    .lag_word (lag_word)
  );

  swb_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (op_t'(s_tuser[0])),
    .in_seed  (s_tdata[WORD_WIDTH-1:0]),
    .out_free (out_free),
    .old_word (old_word),
    .lag_word (lag_word),
    .rd       (rd),
    .wr       (wr),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= stat.result;
    end
  end

  assign s_tready = stat.ready;
  assign m_tdata  = TDATA_W'(out_word);

`ifndef SYNTH
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> stat.valid)
    else $error("accepted request did not reach the update stage");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    stat.valid && !out_free |=> stat.valid && $stable(stat.result))
    else $error("stalled update stage changed its word");

  a_pointer_wraps: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (stat.ptr == PTR_W'(LONG_LAG - 1)) |=> stat.ptr == '0)
    else $error("slot pointer did not wrap to zero");

  a_write_only_on_load: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> load && (wr.data == stat.result))
    else $error("ring written without a word moving to the output");
`endif

endmodule
`default_nettype wire
